// ===== hdl/tcs_pkg.sv =====
// shared types, constants and byte helpers for the text comment stripper
package tcs_pkg;

    localparam int MAX_LINE = 1024;
    localparam int POS_W    = $clog2(MAX_LINE);
    localparam int KEY_LEN  = 8;

    // last chunk position before the length limit closes the chunk
    localparam logic [POS_W-1:0] LAST_POS = POS_W'(MAX_LINE - 2);

    localparam logic [7:0] BYTE_LF    = 8'd10;
    localparam logic [7:0] BYTE_CR    = 8'd13;
    localparam logic [7:0] BYTE_TAB   = 8'd9;
    localparam logic [7:0] BYTE_FF    = 8'd12;
    localparam logic [7:0] BYTE_SPACE = 8'd32;
    localparam logic [7:0] PCT_CHAR   = 8'd37;

    localparam int ADDR_W = 5;

    // register indexes on the configuration port
    localparam logic [2:0] REG_STRIP_WHOLE   = 3'd0;
    localparam logic [2:0] REG_STRIP_INLINE  = 3'd1;
    localparam logic [2:0] REG_STRIP_KEYWORD = 3'd2;
    localparam logic [2:0] REG_LINE_CHAR     = 3'd3;
    localparam logic [2:0] REG_INLINE_CHAR   = 3'd4;
    localparam logic [2:0] REG_CHECK_CTRL    = 3'd5;

    typedef enum logic [4:0] {
        MODE_START = 5'b00001,
        MODE_MATCH = 5'b00010,
        MODE_TRUNC = 5'b00100,
        MODE_PASS  = 5'b01000,
        MODE_DROP  = 5'b10000
    } mode_t;

    // the "Comment " keyword, one byte per index
    function automatic logic [7:0] keyword_byte(input logic [2:0] idx);
        logic [7:0] b;
        unique case (idx)
            3'd0: b = 8'h43;
            3'd1: b = 8'h6f;
            3'd2: b = 8'h6d;
            3'd3: b = 8'h6d;
            3'd4: b = 8'h65;
            3'd5: b = 8'h6e;
            3'd6: b = 8'h74;
            3'd7: b = 8'h20;
            default: b = 8'h20;
        endcase
        return b;
    endfunction

    function automatic logic is_bad_control(input logic [7:0] b);
        return (b < BYTE_SPACE) && (b != BYTE_LF) && (b != BYTE_CR)
            && (b != BYTE_TAB) && (b != BYTE_FF);
    endfunction

endpackage

// ===== hdl/text_comment_stripper.sv =====
// text comment stripper: config registers, chunk state, result run buffer
// an accepted beat passes the input register, then the result run buffer, before its first result shows
// throughput: one beat per cycle while each beat gives at most one result and out_stall is low
// a beat giving n results holds the result buffer until all n are taken (n up to 8)
// the input register takes the next beat while the last result waits
// reset: asynchronous, clears chunk state, run buffer counts and config to defaults
module text_comment_stripper (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_stall,
    input  logic [7:0]                in_byte,
    input  logic                      end_of_stream,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [7:0]                out_byte,
    output logic                      last_of_run,
    output logic                      bad_control,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [tcs_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import tcs_pkg::*;

    logic       strip_whole_lines_reg;
    logic       strip_inline_reg;
    logic       strip_comment_keyword_lines_reg;
    logic [7:0] line_comment_char_reg;
    logic [7:0] inline_comment_char_reg;
    logic       check_controls_reg;

    logic       in_full_reg;
    logic [7:0] in_byte_reg;
    logic       eos_reg;

    mode_t            mode_reg, mode_next, mode_work;
    logic [2:0]       held_reg, held_next, held_eff;
    logic [POS_W-1:0] pos_reg, pos_next;

    logic [3:0] key_count_reg, key_count_next;
    logic [7:0] tail_byte_reg, tail_raw;
    logic       tail_flag_reg;
    logic       has_tail;
    logic [3:0] run_total_reg, run_pos_reg;

    logic       rel_hit;
    logic [3:0] rel_idx;
    logic       run_free;
    logic       load;
    logic       out_take;
    logic [2:0] reg_idx;
    logic       cfg_write;

    // configuration port
    assign pready    = 1'b1;
    assign reg_idx   = paddr[4:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            strip_whole_lines_reg           <= 1'b0;
            strip_inline_reg                <= 1'b0;
            strip_comment_keyword_lines_reg <= 1'b0;
            line_comment_char_reg           <= PCT_CHAR;
            inline_comment_char_reg         <= PCT_CHAR;
            check_controls_reg              <= 1'b0;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_STRIP_WHOLE:   strip_whole_lines_reg           <= pwdata[0];
                REG_STRIP_INLINE:  strip_inline_reg                <= pwdata[0];
                REG_STRIP_KEYWORD: strip_comment_keyword_lines_reg <= pwdata[0];
                REG_LINE_CHAR:     line_comment_char_reg           <= pwdata[7:0];
                REG_INLINE_CHAR:   inline_comment_char_reg         <= pwdata[7:0];
                REG_CHECK_CTRL:    check_controls_reg              <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_STRIP_WHOLE:   prdata = {31'd0, strip_whole_lines_reg};
            REG_STRIP_INLINE:  prdata = {31'd0, strip_inline_reg};
            REG_STRIP_KEYWORD: prdata = {31'd0, strip_comment_keyword_lines_reg};
            REG_LINE_CHAR:     prdata = {24'd0, line_comment_char_reg};
            REG_INLINE_CHAR:   prdata = {24'd0, inline_comment_char_reg};
            REG_CHECK_CTRL:    prdata = {31'd0, check_controls_reg};
            default:           prdata = 32'd0;
        endcase
    end

    // handshakes
    assign out_valid   = (run_pos_reg != run_total_reg);
    assign last_of_run = ((run_pos_reg + 4'd1) == run_total_reg);
    assign out_take    = out_valid && !out_stall;
    assign run_free    = !out_valid || (last_of_run && !out_stall);
    assign load        = in_full_reg && run_free;
    assign in_stall    = in_full_reg && !load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_full_reg <= 1'b0;
        else if (!in_stall)
            in_full_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_byte_reg <= in_byte;
            eos_reg     <= end_of_stream;
        end
    end

    // mode chosen at the first byte of a chunk
    always_comb
    begin
        held_eff  = held_reg;
        mode_work = mode_reg;
        if (mode_reg == MODE_START)
        begin
            held_eff = 3'd0;
            if (strip_whole_lines_reg && (in_byte_reg == line_comment_char_reg))
                mode_work = MODE_DROP;
            else if (strip_inline_reg)
                mode_work = strip_comment_keyword_lines_reg ? MODE_TRUNC : MODE_MATCH;
            else
                mode_work = MODE_PASS;
        end
    end

    // first inline comment byte among the held keyword bytes, position one on
    always_comb
    begin
        rel_hit = 1'b0;
        rel_idx = 4'd0;
        for (int j = KEY_LEN - 1; j >= 1; j--)
        begin
            if ((3'(j) < held_eff) && (keyword_byte(3'(j)) == inline_comment_char_reg))
            begin
                rel_hit = 1'b1;
                rel_idx = 4'(j);
            end
        end
    end

    always_comb
    begin
        mode_next      = mode_reg;
        held_next      = 3'd0;
        pos_next       = pos_reg;
        key_count_next = 4'd0;
        has_tail       = 1'b0;
        tail_raw       = in_byte_reg;

        if (eos_reg)
        begin
            if (mode_reg == MODE_MATCH)
            begin
                if (rel_hit)
                begin
                    key_count_next = rel_idx;
                    has_tail       = 1'b1;
                    tail_raw       = BYTE_LF;
                end
                else
                    key_count_next = {1'b0, held_eff};
            end
            mode_next = MODE_START;
            pos_next  = '0;
        end
        else
        begin
            mode_next = mode_work;
            unique case (mode_work)
                MODE_MATCH:
                begin
                    if (in_byte_reg == keyword_byte(held_eff))
                    begin
                        if (held_eff == 3'(KEY_LEN - 1))
                        begin
                            key_count_next = 4'(KEY_LEN);
                            mode_next      = MODE_PASS;
                        end
                        else
                            held_next = held_eff + 3'd1;
                    end
                    else if (rel_hit)
                    begin
                        key_count_next = rel_idx;
                        has_tail       = 1'b1;
                        tail_raw       = BYTE_LF;
                        mode_next      = MODE_DROP;
                    end
                    else
                    begin
                        key_count_next = {1'b0, held_eff};
                        has_tail       = 1'b1;
                        if ((pos_reg != '0) && (in_byte_reg == inline_comment_char_reg))
                        begin
                            tail_raw  = BYTE_LF;
                            mode_next = MODE_DROP;
                        end
                        else
                            mode_next = MODE_TRUNC;
                    end
                end
                MODE_TRUNC:
                begin
                    has_tail = 1'b1;
                    if ((pos_reg != '0) && (in_byte_reg == inline_comment_char_reg))
                    begin
                        tail_raw  = BYTE_LF;
                        mode_next = MODE_DROP;
                    end
                end
                MODE_PASS:
                    has_tail = 1'b1;
                MODE_DROP: ;
                default: ;
            endcase

            // held bytes cannot reach the length limit for any legal chunk length
            if ((in_byte_reg == BYTE_LF) || (pos_reg >= LAST_POS))
            begin
                mode_next = MODE_START;
                held_next = 3'd0;
                pos_next  = '0;
            end
            else
                pos_next = pos_reg + POS_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_START;
            held_reg      <= 3'd0;
            pos_reg       <= '0;
            run_total_reg <= 4'd0;
            run_pos_reg   <= 4'd0;
        end
        else if (load)
        begin
            mode_reg      <= mode_next;
            held_reg      <= held_next;
            pos_reg       <= pos_next;
            run_total_reg <= key_count_next + {3'd0, has_tail};
            run_pos_reg   <= 4'd0;
        end
        else if (out_take)
            run_pos_reg <= run_pos_reg + 4'd1;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            key_count_reg <= key_count_next;
            if (check_controls_reg && is_bad_control(tail_raw))
            begin
                tail_byte_reg <= BYTE_SPACE;
                tail_flag_reg <= 1'b1;
            end
            else
            begin
                tail_byte_reg <= tail_raw;
                tail_flag_reg <= 1'b0;
            end
        end
    end

    // keyword bytes first, then the tail byte of the beat
    always_comb
    begin
        if (run_pos_reg < key_count_reg)
        begin
            out_byte    = keyword_byte(run_pos_reg[2:0]);
            bad_control = 1'b0;
        end
        else
        begin
            out_byte    = tail_byte_reg;
            bad_control = tail_flag_reg;
        end
    end

    a_held_only_matching: assert property (@(posedge clk) disable iff (!rst_n)
        (held_reg != 3'd0) |-> (mode_reg == MODE_MATCH))
        else $error("held keyword bytes outside keyword matching");

    a_start_at_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (mode_reg == MODE_START) |-> (pos_reg == '0))
        else $error("chunk start with non-zero position");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !last_of_run) |=> out_valid)
        else $error("result run ended before its last beat");

    a_run_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (run_total_reg <= 4'(KEY_LEN)) && (run_pos_reg <= run_total_reg))
        else $error("result run count out of range");

    a_item_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_full_reg && !run_free) |=> in_full_reg)
        else $error("pending beat lost while result buffer busy");

endmodule
